FILE: design/rrts_pkg.sv
// Package for the round robin task scheduler.
// Holds the item types of both channels and the control group sent to the task cells.
// No dependencies.
`default_nettype none
package rrts_pkg;

  typedef struct packed {
    logic        cmd;
    logic [31:0] delay_ticks;
  } evt_t;

  typedef struct packed {
    logic [2:0]  running_task;
    logic [31:0] tick_now;
  } res_t;

  typedef struct packed {
    logic tick;
    logic delay;
    logic load;
    logic shift;
  } cell_ctrl_t;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_DELAY = 1'b1;

endpackage
`default_nettype wire

FILE: design/rrts_cell.sv
// One task cell: blocked flag, wake tick and a scan token passed to the next cell.
// Depends on rrts_pkg.
`default_nettype none
module rrts_cell #(
  parameter int NUM_TASKS = 5,
  parameter int INDEX     = 0,
  localparam int CW       = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rrts_pkg::cell_ctrl_t ctrl,
  input  wire logic [CW-1:0]       cur,
  input  wire logic [31:0]         sum,
  input  wire logic                tok_in,
  output logic                     tok_out,
  output logic                     hit
);

  logic        blocked;
  logic [31:0] wake;
  logic        tok;
  logic        sel;

  assign sel     = (cur == CW'(INDEX));
  assign tok_out = tok;
  assign hit     = ctrl.shift & tok_in & ~blocked & (INDEX != 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked <= 1'b0;
      wake    <= '0;
      tok     <= 1'b0;
    end else begin
      if (ctrl.tick && blocked && (wake == sum)) begin
        blocked <= 1'b0;
      end else if (ctrl.delay && sel) begin
        blocked <= 1'b1;
        wake    <= sum;
      end
      if (ctrl.load) begin
        tok <= sel;
      end else if (ctrl.shift) begin
        tok <= tok_in;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/round_robin_task_scheduler_top.sv
// Round robin task scheduler with tick delays: top level, sequencer and cell ring.
// Depends on rrts_pkg and rrts_cell.
//
// Usage:
//   evt channel (evt_valid/evt_ready/evt) takes one event item: cmd 0 is a timer
//   tick, cmd 1 a delay request from the running task with delay_ticks.
//   res channel (res_valid/res_ready/res) returns one item per event: the task
//   that runs next and the tick counter after the event.
// Timing: the accept cycle updates the counter and the cells; a token then walks
//   the ring of task cells one cell per cycle until a ready task is met, else the
//   idle task 0 is chosen; the DONE state then writes the result register. A delay
//   from the idle task skips the walk. One event is in work at a time; evt_ready
//   is high while no event is in work.
// Reset: every task ready, all wake ticks and the counter zero, task 1 running.
// Stall: a waiting result holds; a new event may be accepted meanwhile, and its
//   result waits in the sequencer until the result register is taken.
`default_nettype none
module round_robin_task_scheduler_top #(
  parameter int NUM_TASKS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           evt_valid,
  output logic                evt_ready,
  input  wire rrts_pkg::evt_t evt,
  output logic                res_valid,
  input  wire logic           res_ready,
  output rrts_pkg::res_t      res
);

  localparam int CW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  logic [CW-1:0]        cur;
  logic [CW-1:0]        step;
  logic [31:0]          counter;
  logic [31:0]          sum;
  logic                 accept;
  logic                 any_hit;
  logic [CW-1:0]        chosen;
  rrts_pkg::cell_ctrl_t ctrl;
  logic [NUM_TASKS-1:0] tok;
  logic [NUM_TASKS-1:0] hit;

  assign evt_ready = (state == ST_IDLE);
  assign accept    = evt_valid & evt_ready;
  assign sum       = counter + ((evt.cmd == rrts_pkg::CMD_DELAY) ? evt.delay_ticks : 32'd1);

  always_comb begin
    ctrl.tick  = accept & (evt.cmd == rrts_pkg::CMD_TICK);
    ctrl.delay = accept & (evt.cmd == rrts_pkg::CMD_DELAY) & (cur != '0);
    ctrl.load  = ctrl.tick | ctrl.delay;
    ctrl.shift = (state == ST_SCAN);
  end

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    rrts_cell #(
      .NUM_TASKS(NUM_TASKS),
      .INDEX    (i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .cur    (cur),
      .sum    (sum),
      .tok_in (tok[(i + NUM_TASKS - 1) % NUM_TASKS]),
      .tok_out(tok[i]),
      .hit    (hit[i])
    );
  end

  always_comb begin
    any_hit = |hit;
    chosen  = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      chosen = chosen | (hit[i] ? CW'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= CW'(1);
      step      <= '0;
      counter   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != ST_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            step <= '0;
            if (ctrl.tick) begin
              counter <= sum;
            end
            state <= ctrl.load ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          step <= step + CW'(1);
          if (any_hit || (step == CW'(NUM_TASKS - 1))) begin
            cur   <= chosen;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            res.running_task <= 3'(cur);
            res.tick_now     <= counter;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
